[design/chunk_hash_table_insert_find_macros.svh]
// Assertion macros for the match table design file.
`ifndef CHUNK_HASH_TABLE_INSERT_FIND_MACROS_SVH
`define CHUNK_HASH_TABLE_INSERT_FIND_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CHTIF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define CHTIF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/chtif_pkg.sv]
package chtif_pkg;

   // Default sizes of the stores and the walk
   localparam int SLOT_DEPTH_DEF  = 131072;
   localparam int CHUNK_DEPTH_DEF = 65536;
   localparam int MAX_PROBES_DEF  = 12;

   // Payload widths
   localparam int FUNC_W  = 1;
   localparam int HASH_W  = 64;
   localparam int CHUNK_W = 16;
   localparam int WORD_W  = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_LOG2 = 4'd0,
      CSR_CHUNK_BITS = 4'd1
   } csr_idx_type;

   localparam logic [CFG_W-1:0] TABLE_LOG2_RESET = 5'd17;
   localparam logic [CFG_W-1:0] CHUNK_BITS_RESET = 5'd16;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 1'b1;

   localparam logic [CHUNK_W-1:0] CHUNK_NONE = 16'd0;

   // Scramble applied at a jump
   localparam logic [WORD_W-1:0] JUMP_MUL = 32'd123456791;
   localparam logic [WORD_W-1:0] JUMP_ADD = 32'd462782923;

   // Index reduction unit: input width
   localparam int MOD_IN_W    = 32;

endpackage

[design/chtif_req_if.sv]
interface chtif_req_if;
   import chtif_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [HASH_W-1:0]   hash_value;
   logic [CHUNK_W-1:0]  chunk_number;

   modport source (output valid, func, hash_value, chunk_number, input ready);
   modport sink   (input valid, func, hash_value, chunk_number, output ready);
endinterface

[design/chtif_rsp_if.sv]
interface chtif_rsp_if;
   import chtif_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHUNK_W-1:0]  found_chunk;

   modport source (output valid, found_chunk, input ready);
   modport sink   (input valid, found_chunk, output ready);
endinterface

[design/chtif_csr_if.sv]
interface chtif_csr_if;
   import chtif_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/chtif_ram.sv]
module chtif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on we, register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[design/chtif_mod.sv]
module chtif_mod #(
   parameter int DIVISOR = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [chtif_pkg::MOD_IN_W-1:0]  value,
   output logic                            done,
   output logic [$clog2(DIVISOR)-1:0]      result
);
   import chtif_pkg::*;

   localparam int  RES_W = $clog2(DIVISOR);
   localparam bit  POW2  = (DIVISOR & (DIVISOR - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         // Power of two: keep the low bits, answer at once
         assign done   = start;
         assign result = value[RES_W-1:0];
      end else begin : g_recip
         localparam int PROD_W = 2 * MOD_IN_W;
         localparam int REM_W  = RES_W + 1;
         // floor(2^32 / DIVISOR): the quotient estimate is low by at most one
         localparam logic [PROD_W-1:0]   RECIP_WIDE =
            (PROD_W'(1) << MOD_IN_W) / PROD_W'(DIVISOR);
         localparam logic [MOD_IN_W-1:0] RECIP = RECIP_WIDE[MOD_IN_W-1:0];
         localparam logic [REM_W-1:0]    DIV_R = REM_W'(DIVISOR);

         logic              mul_vld_ff, sub_vld_ff, done_ff;
         logic [PROD_W-1:0] prod_ff, prod_in;
         logic [REM_W-1:0]  low_ff, low_in;
         logic [REM_W-1:0]  rem_ff, rem_in;
         logic [RES_W-1:0]  res_ff, res_in;
         logic [REM_W-1:0]  quot_low;
         logic              launch;

         assign launch   = start && !mul_vld_ff && !sub_vld_ff && !done_ff;
         assign quot_low = prod_ff[MOD_IN_W +: REM_W];

         always_comb begin
            prod_in = prod_ff;
            low_in  = low_ff;
            rem_in  = rem_ff;
            res_in  = res_ff;
            // Estimate the quotient with the reciprocal
            if (launch) begin
               prod_in = PROD_W'(value) * PROD_W'(RECIP);
               low_in  = value[REM_W-1:0];
            end
            // Remainder of the estimate, below twice the divisor
            if (mul_vld_ff) begin
               rem_in = low_ff - quot_low * DIV_R;
            end
            // Subtract the divisor once if still too large
            if (sub_vld_ff) begin
               res_in = (rem_ff >= DIV_R) ? RES_W'(rem_ff - DIV_R) : rem_ff[RES_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mul_vld_ff <= 1'b0;
               sub_vld_ff <= 1'b0;
               done_ff    <= 1'b0;
            end else begin
               mul_vld_ff <= launch;
               sub_vld_ff <= mul_vld_ff;
               done_ff    <= sub_vld_ff;
            end
            prod_ff <= prod_in;
            low_ff  <= low_in;
            rem_ff  <= rem_in;
            res_ff  <= res_in;
         end

         assign done   = done_ff;
         assign result = res_ff;
      end
   endgenerate
endmodule

[design/chunk_hash_table_insert_find.sv]
// Deduplication match table with a bounded open-addressing walk.
// req: one beat per chunk: func (insert or find), 64-bit hash, chunk number.
// rsp: one beat per request: found_chunk, the earlier chunk whose hash matches,
//      zero when none. Beats come back in request order.
// csr: writes table_log2 (index 0) and chunk_bits (index 1); always ready.
//      Write it only while no request is in flight.
// One request at a time. Each probe computes the index and reads a slot,
// plus a chunk index step and a read of the stored upper hash word when the
// tag matches, plus the multiply steps ST_MUL1 to ST_MUL3 at each of the two
// jumps. An insert first adds the store write.
// A depth that is not a power of two adds the reduction unit's registers to each index.
// Reset: the slot memory is cleared one entry a cycle, all SLOT_DEPTH entries, with
// req_if.ready low; csr writes are taken meanwhile.
// Stall: the result sits in an output register; the next request is taken
// while it waits, and the walk holds at its end only if that register is full.
module chunk_hash_table_insert_find #(
   parameter int SLOT_DEPTH  = chtif_pkg::SLOT_DEPTH_DEF,
   parameter int CHUNK_DEPTH = chtif_pkg::CHUNK_DEPTH_DEF,
   parameter int MAX_PROBES  = chtif_pkg::MAX_PROBES_DEF
) (
   input logic        clock,
   input logic        reset,
   chtif_req_if.sink  req_if,
   chtif_rsp_if.source rsp_if,
   chtif_csr_if.sink  csr_if
);
   import chtif_pkg::*;

   `include "chunk_hash_table_insert_find_macros.svh"

   localparam int SLOT_AW  = $clog2(SLOT_DEPTH);
   localparam int CHUNK_AW = $clog2(CHUNK_DEPTH);
   localparam int LIM_W    = $clog2(MAX_PROBES + 1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_CLR    = 11'b00000000010,
      ST_CIDX_W = 11'b00000000100,
      ST_IDX    = 11'b00000001000,
      ST_SRD    = 11'b00000010000,
      ST_CIDX_R = 11'b00000100000,
      ST_HRD    = 11'b00001000000,
      ST_MUL1   = 11'b00010000000,
      ST_MUL2   = 11'b00100000000,
      ST_MUL3   = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [CFG_W-1:0]     table_log2_ff, table_log2_in;
   logic [CFG_W-1:0]     chunk_bits_ff, chunk_bits_in;
   logic                 insert_ff, insert_in;
   logic                 write_slot_ff, write_slot_in;
   logic [HASH_W-1:0]    h_ff, h_in;
   logic [HASH_W-1:0]    prod_ff, prod_in;
   logic [WORD_W-1:0]    upper_ff, upper_in;
   logic [WORD_W-1:0]    tag_ff, tag_in;
   logic [WORD_W-1:0]    num_mask_ff, num_mask_in;
   logic [WORD_W-1:0]    value_ff, value_in;
   logic [CHUNK_W-1:0]   new_chunk_ff, new_chunk_in;
   logic [CHUNK_W-1:0]   found_ff, found_in;
   logic [LIM_W-1:0]     limit_ff, limit_in;
   logic [SLOT_AW-1:0]   slot_addr_ff, slot_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHUNK_W-1:0]   rsp_found_ff, rsp_found_in;

   logic [WORD_W:0]      num_mask_wide;
   logic [WORD_W-1:0]    table_mask;
   logic [WORD_W-1:0]    chunk_of_value;
   logic [LIM_W-1:0]     limit_dec;
   logic [HASH_W-1:0]    mul_lo;
   logic [WORD_W-1:0]    mul_hi;

   logic                 slot_start, slot_done;
   logic [SLOT_AW-1:0]   slot_idx;
   logic                 chunk_start, chunk_done;
   logic [MOD_IN_W-1:0]  chunk_value;
   logic [CHUNK_AW-1:0]  chunk_idx;

   logic                 slot_we;
   logic [SLOT_AW-1:0]   slot_addr;
   logic [WORD_W-1:0]    slot_wdata, slot_rdata;
   logic                 store_we;
   logic [WORD_W-1:0]    store_rdata;

   // Masks from the configuration
   assign num_mask_wide  = ((WORD_W + 1)'(1) << chunk_bits_ff) - (WORD_W + 1)'(1);
   assign table_mask     = (WORD_W'(1) << table_log2_ff) - WORD_W'(1);
   assign chunk_of_value = value_ff & num_mask_ff;
   assign limit_dec      = limit_ff - 1'b1;

   // Jump scramble split into two 32-bit products
   assign mul_lo = HASH_W'(h_ff[WORD_W-1:0]) * HASH_W'(JUMP_MUL);
   assign mul_hi = h_ff[HASH_W-1:WORD_W] * JUMP_MUL;

   // Index reduction units
   assign slot_start  = (state_ff == ST_IDX);
   assign chunk_start = (state_ff == ST_CIDX_W) || (state_ff == ST_CIDX_R);
   assign chunk_value = (state_ff == ST_CIDX_W) ? MOD_IN_W'(new_chunk_ff) : chunk_of_value;

   chtif_mod #(.DIVISOR(SLOT_DEPTH)) u_slot_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (slot_start),
      .value  (h_ff[MOD_IN_W-1:0] & table_mask),
      .done   (slot_done),
      .result (slot_idx)
   );

   chtif_mod #(.DIVISOR(CHUNK_DEPTH)) u_chunk_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (chunk_start),
      .value  (chunk_value),
      .done   (chunk_done),
      .result (chunk_idx)
   );

   // Slot memory: clear sweep, probe reads, final write
   always_comb begin
      slot_we    = 1'b0;
      slot_addr  = slot_idx;
      slot_wdata = tag_ff + WORD_W'(new_chunk_ff);
      if (state_ff == ST_CLR) begin
         slot_we    = 1'b1;
         slot_addr  = clr_cnt_ff;
         slot_wdata = '0;
      end else if (state_ff == ST_DONE) begin
         slot_we   = write_slot_ff;
         slot_addr = slot_addr_ff;
      end
   end

   assign store_we = (state_ff == ST_CIDX_W) && chunk_done;

   chtif_ram #(.WIDTH(WORD_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .addr  (slot_addr),
      .wdata (slot_wdata),
      .rdata (slot_rdata)
   );

   chtif_ram #(.WIDTH(WORD_W), .DEPTH(CHUNK_DEPTH)) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .addr  (chunk_idx),
      .wdata (upper_ff),
      .rdata (store_rdata)
   );

   // Walk sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      table_log2_in = table_log2_ff;
      chunk_bits_in = chunk_bits_ff;
      insert_in     = insert_ff;
      write_slot_in = write_slot_ff;
      h_in          = h_ff;
      prod_in       = prod_ff;
      upper_in      = upper_ff;
      tag_in        = tag_ff;
      num_mask_in   = num_mask_ff;
      value_in      = value_ff;
      new_chunk_in  = new_chunk_ff;
      found_in      = found_ff;
      limit_in      = limit_ff;
      slot_addr_in  = slot_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;

      // Drop the result beat once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_TABLE_LOG2: table_log2_in = csr_if.data[CFG_W-1:0];
            CSR_CHUNK_BITS: chunk_bits_in = csr_if.data[CFG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_AW'(SLOT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               insert_in     = (req_if.func == FUNC_INSERT);
               write_slot_in = (req_if.func == FUNC_INSERT);
               h_in          = req_if.hash_value;
               upper_in      = req_if.hash_value[HASH_W-1:WORD_W];
               num_mask_in   = num_mask_wide[WORD_W-1:0];
               tag_in        = req_if.hash_value[WORD_W-1:0] & ~num_mask_wide[WORD_W-1:0];
               new_chunk_in  = req_if.chunk_number;
               found_in      = CHUNK_NONE;
               limit_in      = LIM_W'(MAX_PROBES);
               state_in      = (req_if.func == FUNC_INSERT) ? ST_CIDX_W : ST_IDX;
            end
         end
         ST_CIDX_W: begin
            // Store the upper hash word of the new chunk
            if (chunk_done) begin
               if (new_chunk_ff == CHUNK_NONE) begin
                  write_slot_in = 1'b0;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_IDX;
               end
            end
         end
         ST_IDX: begin
            if (slot_done) begin
               slot_addr_in = slot_idx;
               state_in     = ST_SRD;
            end
         end
         ST_SRD: begin
            value_in = slot_rdata;
            if (slot_rdata == '0) begin
               state_in = ST_DONE;
            end else begin
               limit_in = limit_dec;
               if (limit_dec == '0) begin
                  state_in = ST_DONE;
               end else if ((slot_rdata & ~num_mask_ff) == tag_ff) begin
                  state_in = ST_CIDX_R;
               end else begin
                  h_in     = h_ff + 1'b1;
                  state_in = (limit_dec[1:0] == 2'b00) ? ST_MUL1 : ST_IDX;
               end
            end
         end
         ST_CIDX_R: begin
            if (chunk_done) begin
               state_in = ST_HRD;
            end
         end
         ST_HRD: begin
            // Confirm the match against the stored upper word
            if (store_rdata == upper_ff) begin
               found_in = chunk_of_value[CHUNK_W-1:0];
               state_in = ST_DONE;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = (limit_ff[1:0] == 2'b00) ? ST_MUL1 : ST_IDX;
            end
         end
         ST_MUL1: begin
            prod_in  = mul_lo;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = prod_ff + {mul_hi, WORD_W'(0)};
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            h_in     = prod_ff + (h_ff >> 16) + HASH_W'(JUMP_ADD);
            state_in = ST_IDX;
         end
         ST_DONE: begin
            // Hand the result to the output register when it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               write_slot_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_cnt_ff    <= '0;
         table_log2_ff <= TABLE_LOG2_RESET;
         chunk_bits_ff <= CHUNK_BITS_RESET;
         write_slot_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         table_log2_ff <= table_log2_in;
         chunk_bits_ff <= chunk_bits_in;
         write_slot_ff <= write_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      insert_ff    <= insert_in;
      h_ff         <= h_in;
      prod_ff      <= prod_in;
      upper_ff     <= upper_in;
      tag_ff       <= tag_in;
      num_mask_ff  <= num_mask_in;
      value_ff     <= value_in;
      new_chunk_ff <= new_chunk_in;
      found_ff     <= found_in;
      limit_ff     <= limit_in;
      slot_addr_ff <= slot_addr_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found_chunk = rsp_found_ff;

   // Checks
   `CHTIF_ASSERT_NOW(a_slot_idx_when_probing, slot_done, state_ff == ST_IDX,
      "slot index ready outside a probe")
   `CHTIF_ASSERT_NOW(a_chunk_idx_when_needed, chunk_done,
      state_ff == ST_CIDX_W || state_ff == ST_CIDX_R, "chunk index ready out of turn")
   `CHTIF_ASSERT_NOW(a_slot_write_place, slot_we,
      state_ff == ST_CLR || (state_ff == ST_DONE && insert_ff), "unexpected slot write")
   `CHTIF_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == ST_DONE),
      "result beat raised outside the done step")
endmodule

[sim/chunk_hash_table_insert_find_tb.sv]
`timescale 1ns / 1ps

module chunk_hash_table_insert_find_tb;
   import chtif_pkg::*;

   localparam int SLOTS  = SLOT_DEPTH_DEF;
   localparam int CHUNKS = CHUNK_DEPTH_DEF;
   localparam int PROBES = MAX_PROBES_DEF;

   localparam int STALL_LIMIT   = 400000;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 110;
   localparam int POOL_SIZE     = 64;
   localparam int DRAIN_CYCLES  = 50;

   // Table size and chunk field width for each random phase
   localparam int PHASE_LOG2 [PHASES] = '{4, 1, 0, 31, 17, 31, 10, 20, 6, 12};
   localparam int PHASE_CB   [PHASES] = '{3, 1, 2, 0, 16, 31, 8, 16, 5, 14};

   // Mirror of the match table: walks its own copy of the slots and the upper-word store
   class match_table_model;
      bit [WORD_W-1:0]  slot_word [SLOTS];
      bit [WORD_W-1:0]  upper_word [CHUNKS];
      bit               upper_known [CHUNKS];
      logic [CFG_W-1:0] table_log2 = TABLE_LOG2_RESET;
      logic [CFG_W-1:0] chunk_bits = CHUNK_BITS_RESET;
      logic [CHUNK_W-1:0] found_due [$];
      int unsigned      miss_idx;
      int               fails;

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_TABLE_LOG2)
            table_log2 = data[CFG_W-1:0];
         else if (idx == CSR_CHUNK_BITS)
            chunk_bits = data[CFG_W-1:0];
      endfunction

      function int unsigned slot_of(input logic [HASH_W-1:0] h);
         logic [HASH_W-1:0] m;
         m = (64'd1 << table_log2) - 64'd1;
         return int'((h & m) % 64'(SLOTS));
      endfunction

      // Walk the table for one request; commit applies the writes. Returns 0 when the
      // walk would read a store entry that was never written.
      function bit walk(input logic [FUNC_W-1:0] func, input logic [HASH_W-1:0] hv,
                        input logic [CHUNK_W-1:0] chunk, input bit commit,
                        output logic [CHUNK_W-1:0] found);
         bit                is_ins;
         logic [WORD_W-1:0] upper, num_mask, tag_mask, tag, entry, c, stored;
         logic [HASH_W-1:0] h, wide_mask;
         int                budget;
         int unsigned       ci;
         is_ins    = (func == FUNC_INSERT);
         upper     = hv[63:32];
         wide_mask = (64'd1 << chunk_bits) - 64'd1;
         num_mask  = wide_mask[WORD_W-1:0];
         tag_mask  = ~num_mask;
         tag       = hv[WORD_W-1:0] & tag_mask;
         h         = hv;
         budget    = PROBES;
         found     = CHUNK_NONE;
         if (is_ins && commit) begin
            upper_word[chunk % CHUNKS]  = upper;
            upper_known[chunk % CHUNKS] = 1'b1;
         end
         // chunk zero only lands in the store
         if (is_ins && chunk == CHUNK_NONE)
            return 1'b1;
         forever begin
            entry = slot_word[slot_of(h)];
            if (entry == '0)
               break;
            budget--;
            if (budget <= 0)
               break;
            if ((entry & tag_mask) == tag) begin
               c  = entry & num_mask;
               ci = c % CHUNKS;
               if (is_ins && ci == chunk % CHUNKS)
                  stored = upper;
               else if (!upper_known[ci]) begin
                  miss_idx = ci;
                  return 1'b0;
               end else
                  stored = upper_word[ci];
               if (stored == upper) begin
                  found = c[CHUNK_W-1:0];
                  break;
               end
            end
            h++;
            // scramble after every fourth probe
            if ((budget & 3) == 0)
               h = h * 64'(JUMP_MUL) + (h >> 16) + 64'(JUMP_ADD);
         end
         if (is_ins && commit)
            slot_word[slot_of(h)] = tag + {16'd0, chunk};
         return 1'b1;
      endfunction

      function bit is_safe(input logic [FUNC_W-1:0] func, input logic [HASH_W-1:0] hv,
                           input logic [CHUNK_W-1:0] chunk);
         logic [CHUNK_W-1:0] unused;
         return walk(func, hv, chunk, 1'b0, unused);
      endfunction

      function void note_request(input logic [FUNC_W-1:0] func, input logic [HASH_W-1:0] hv,
                                 input logic [CHUNK_W-1:0] chunk);
         logic [CHUNK_W-1:0] found;
         void'(walk(func, hv, chunk, 1'b1, found));
         found_due.push_back(found);
      endfunction

      function void check_found(input logic [CHUNK_W-1:0] actual);
         logic [CHUNK_W-1:0] want;
         if (found_due.size() == 0) begin
            $error("found_chunk: expected none, actual %0h", actual);
            fails++;
         end else begin
            want = found_due.pop_front();
            if (actual !== want) begin
               $error("found_chunk: expected %0h, actual %0h", want, actual);
               fails++;
            end
         end
      endfunction

      function int pending();
         return found_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;

   chtif_req_if req_bus();
   chtif_rsp_if rsp_bus();
   chtif_csr_if csr_bus();

   match_table_model   match_model = new();
   logic [HASH_W-1:0]  hash_pool [$];

   chunk_hash_table_insert_find DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none in calm stretches
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHUNK_W-1:0] fresh_chunk();
      int unsigned top;
      int          r;
      r = $urandom_range(0, 99);
      top = (match_model.chunk_bits >= CHUNK_W) ? 32'hFFFF : (1 << match_model.chunk_bits) - 1;
      if (top == 0)
         top = 1;
      if (r < 5)
         return CHUNK_NONE;
      if (r < 15)
         return 16'($urandom);
      return 16'($urandom_range(1, top));
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[CFG_W-1:0] = value;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      match_model.set_reg(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_req(input logic [FUNC_W-1:0] func, input logic [HASH_W-1:0] hv,
                           input logic [CHUNK_W-1:0] chunk);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= func;
      req_bus.hash_value   <= hv;
      req_bus.chunk_number <= chunk;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      match_model.note_request(func, hv, chunk);
      if (func == FUNC_INSERT) begin
         hash_pool.push_back(hv);
         if (hash_pool.size() > POOL_SIZE)
            void'(hash_pool.pop_front());
      end
   endtask

   // Drop valid and hold until every result is back
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (match_model.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Mostly hits, duplicates and tag collisions on known hashes, plus fresh noise
   task automatic draw_request(output logic [FUNC_W-1:0] func, output logic [HASH_W-1:0] hv,
                               output logic [CHUNK_W-1:0] chunk);
      int pick;
      for (int tries = 0; tries < 8; tries++) begin
         pick  = $urandom_range(0, 99);
         func  = FUNC_INSERT;
         chunk = fresh_chunk();
         hv    = (hash_pool.size() == 0) ? {$urandom, $urandom}
                                         : hash_pool[$urandom_range(0, hash_pool.size() - 1)];
         if (pick < 30)
            hv = {$urandom, $urandom};
         else if (pick < 50)
            func = FUNC_FIND;
         else if (pick < 62)
            hv[63:32] = $urandom;
         else if (pick < 75) begin
            func = FUNC_FIND;
            hv   = {$urandom, $urandom};
         end else if (pick < 85) begin
            func = FUNC_FIND;
            hv[63:32] = $urandom;
         end
         if (func == FUNC_FIND)
            chunk = 16'($urandom);
         if (match_model.is_safe(func, hv, chunk))
            return;
      end
      // fill the store entry the walk tripped on, else fall back to chunk zero
      func  = FUNC_INSERT;
      hv    = {$urandom, $urandom};
      chunk = match_model.miss_idx[CHUNK_W-1:0];
      if (!match_model.is_safe(func, hv, chunk))
         chunk = CHUNK_NONE;
   endtask

   // Result side: random stalls, check every beat
   initial begin : rsp_sink
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            match_model.check_found(rsp_bus.found_chunk);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            hold = gap_len();
            rsp_bus.ready <= (hold == 0);
            if (hold > 0)
               hold--;
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [FUNC_W-1:0]  func;
      logic [HASH_W-1:0]  hv;
      logic [CHUNK_W-1:0] chunk;
      logic [HASH_W-1:0]  ha;
      reset                <= 1'b1;
      calm                 = 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.func         <= FUNC_INSERT;
      req_bus.hash_value   <= '0;
      req_bus.chunk_number <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_TABLE_LOG2;
      csr_bus.data         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers take writes while the slot memory clears
      csr_write(CSR_TABLE_LOG2, TABLE_LOG2_RESET);
      csr_write(CSR_CHUNK_BITS, CHUNK_BITS_RESET);

      // Directed: chunk zero, empty table, hit and replace, extremes
      ha = 64'hDEAD_BEEF_0000_1234;
      send_req(FUNC_INSERT, 64'h0123_4567_89AB_CDEF, CHUNK_NONE);
      send_req(FUNC_FIND, '0, '0);
      send_req(FUNC_INSERT, ha, 16'd1);
      send_req(FUNC_FIND, ha, 16'd0);
      send_req(FUNC_INSERT, ha, 16'd2);
      send_req(FUNC_FIND, ha, 16'hFFFF);
      send_req(FUNC_INSERT, '1, 16'hFFFF);
      send_req(FUNC_FIND, '1, 16'h0);
      send_req(FUNC_FIND, '0, 16'hFFFF);
      // Same tag, different upper words: walk past each and run into the probe limit
      for (int k = 0; k < 12; k++)
         send_req(FUNC_INSERT, {32'hC0DE_0000 | 32'(k), 32'h0005_A5A5}, 16'(100 + k));
      send_req(FUNC_FIND, {32'hC0DE_0000, 32'h0005_A5A5}, '0);
      send_req(FUNC_FIND, {32'hC0DE_000B, 32'h0005_A5A5}, '0);
      send_req(FUNC_FIND, {32'hC0DE_0005, 32'h0005_A5A5}, '0);
      send_req(FUNC_FIND, {32'h1111_2222, ha[31:0]}, '0);

      // Random phases over several table and chunk field settings
      for (int p = 0; p < PHASES; p++) begin
         settle();
         csr_write(CSR_TABLE_LOG2, 5'(PHASE_LOG2[p]));
         csr_write(CSR_CHUNK_BITS, 5'(PHASE_CB[p]));
         if (p == 3)
            csr_write({CSR_IDX_W{1'b1}}, 5'($urandom));
         calm = (p == 2 || p == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once until the pipe is empty
            if (p == 1 && n == PHASE_ITEMS / 2)
               settle();
            draw_request(func, hv, chunk);
            send_req(func, hv, chunk);
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (match_model.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (match_model.fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/chtif_pkg.sv
design/chtif_req_if.sv
design/chtif_rsp_if.sv
design/chtif_csr_if.sv
design/chtif_ram.sv
design/chtif_mod.sv
design/chunk_hash_table_insert_find.sv
sim/chunk_hash_table_insert_find_tb.sv
